### hdl/cht_pkg.sv
// cht_pkg: shared types and constants of the chained hash table engine.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package cht_pkg;

	localparam int DATA_W      = 64;
	localparam int FUNC_W      = 2;
	localparam int CFG_W       = 7;
	localparam int CFG_RESET   = 64;
	localparam int KEY_SHIFT   = 4;                    // key grain of 16
	localparam int DIV_W       = DATA_W - KEY_SHIFT;   // hashed part of the key
	localparam int HASH_RADIX  = 6;                    // dividend bits per cycle
	localparam int HASH_STEPS  = DIV_W / HASH_RADIX;
	localparam int HASH_CNT_W  = 4;
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_GET    = 2'd2,
		FUNC_REMOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		FOP_CLR = 2'd0,
		FOP_INC = 2'd1,
		FOP_DEC = 2'd2
	} fill_op_t;

	typedef struct packed {
		logic     load_in;
		logic     hash_start;
		logic     idx_clr;
		logic     idx_inc;
		logic     fill_ld;
		logic     hit_ld;
		logic     drop_set;
		logic     rd_next;
		logic     wr_at_fill;
		logic     key_we;
		logic     val_we;
		logic     shift_wr;
		logic     fill_we;
		fill_op_t fill_op;
		logic     clr_inc;
		logic     out_ld;
	} cht_cmd_t;

	typedef struct packed {
		logic  hash_done;
		logic  clr_last;
		func_t func;
		logic  idx_lt_fill;
		logic  idx1_lt_fill;
		logic  key_match;
		logic  full;
		logic  out_free;
	} cht_sts_t;

endpackage

### hdl/cht_hash.sv
// cht_hash: iterative modulo unit, (key / 16) mod bucket count.
// Six dividend bits per cycle, restoring steps. Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cht_pkg::DIV_W-1:0] dividend,
	input  logic [cht_pkg::CFG_W-1:0] divisor,
	output logic                      done,
	output logic [cht_pkg::CFG_W-1:0] rem
);
	import cht_pkg::*;

	logic [DIV_W-1:0]      dvd_q;
	logic [CFG_W-1:0]      dsr_q;
	logic [CFG_W-1:0]      rem_q;
	logic [HASH_CNT_W-1:0] cnt_q;
	logic                  done_q;
	logic [CFG_W-1:0]      rem_nxt;

	always_comb begin
		logic [CFG_W:0]   t;
		logic [CFG_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < HASH_RADIX; k++) begin
			t = {r, dvd_q[DIV_W-1-k]};
			if (t >= {1'b0, dsr_q}) begin
				r = CFG_W'(t - {1'b0, dsr_q});
			end else begin
				r = CFG_W'(t);
			end
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= HASH_CNT_W'(HASH_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == HASH_CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << HASH_RADIX;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### hdl/cht_dp.sv
// cht_dp: datapath of the hash table: config register, key/value/fill memories,
// scan index, result and output registers. Depends on cht_pkg and cht_hash.
`timescale 1ns / 1ps
module cht_dp #(
	parameter int NUM_BUCKETS  = 64,
	parameter int BUCKET_DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [cht_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic [cht_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  cht_pkg::cht_cmd_t               cmd,
	output cht_pkg::cht_sts_t               sts,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cht_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cht_pkg::*;

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int FW = $clog2(BUCKET_DEPTH + 1);
	localparam int ND = NUM_BUCKETS * BUCKET_DEPTH;
	localparam int AW = (ND > 1) ? $clog2(ND) : 1;

	logic [CFG_W-1:0]  bc_q;
	logic [CFG_W-1:0]  divisor;
	func_t             func_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;
	logic              hash_done;
	logic [CFG_W-1:0]  hash_rem;
	logic [BW-1:0]     bucket;
	logic [BW-1:0]     clr_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     idx_q;
	logic [FW-1:0]     fill_rd_q;
	logic [FW-1:0]     fill_wd;
	logic [BW-1:0]     fill_waddr;
	logic [AW-1:0]     base;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] key_rd_q;
	logic [DATA_W-1:0] val_rd_q;
	logic [DATA_W-1:0] key_wd;
	logic [DATA_W-1:0] val_wd;
	logic              found_q;
	logic [DATA_W-1:0] old_q;
	logic              drop_q;
	logic              m_tvalid_q;
	logic              out_found_q;
	logic [DATA_W-1:0] out_old_q;
	logic              out_drop_q;

	logic [DATA_W-1:0] key_mem  [ND];
	logic [DATA_W-1:0] val_mem  [ND];
	logic [FW-1:0]     fill_mem [NUM_BUCKETS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= CFG_W'(CFG_RESET);
		end else if (cfg_wen) begin
			bc_q <= cfg_wdata;
		end
	end

	// zero means one bucket, above the table size saturates
	always_comb begin
		if (bc_q == '0) begin
			divisor = CFG_W'(1);
		end else if (int'(bc_q) > NUM_BUCKETS) begin
			divisor = CFG_W'(NUM_BUCKETS);
		end else begin
			divisor = bc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q  <= func_t'(s_tdata[FUNC_W-1:0]);
			key_q   <= s_tdata[FUNC_W +: DATA_W];
			value_q <= s_tdata[FUNC_W+DATA_W +: DATA_W];
		end
	end

	cht_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.hash_start),
		.dividend (s_tdata[FUNC_W+KEY_SHIFT +: DIV_W]),
		.divisor  (divisor),
		.done     (hash_done),
		.rem      (hash_rem)
	);

	assign bucket = BW'(hash_rem);

	// fill counts: cleared by a sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_inc) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		unique case (cmd.fill_op)
			FOP_INC: fill_wd = fill_q + 1'b1;
			FOP_DEC: fill_wd = fill_q - 1'b1;
			default: fill_wd = '0;
		endcase
	end

	assign fill_waddr = (cmd.fill_op == FOP_CLR) ? clr_q : bucket;

	always_ff @(posedge clk) begin
		if (cmd.fill_we) begin
			fill_mem[fill_waddr] <= fill_wd;
		end
		fill_rd_q <= fill_mem[bucket];
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_ld) begin
			fill_q <= fill_rd_q;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign base    = AW'(bucket) * AW'(BUCKET_DEPTH);
	assign rd_addr = base + (cmd.rd_next ? AW'(idx_q) + AW'(1) : AW'(idx_q));
	assign wr_addr = base + AW'(cmd.wr_at_fill ? fill_q : idx_q);
	assign key_wd  = cmd.shift_wr ? key_rd_q : key_q;
	assign val_wd  = cmd.shift_wr ? val_rd_q : value_q;

	always_ff @(posedge clk) begin
		if (cmd.key_we) begin
			key_mem[wr_addr] <= key_wd;
		end
		key_rd_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			val_mem[wr_addr] <= val_wd;
		end
		val_rd_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			found_q <= 1'b0;
			old_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (cmd.hit_ld) begin
				found_q <= 1'b1;
				old_q   <= val_rd_q;
			end
			if (cmd.drop_set) begin
				drop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_found_q <= found_q;
			out_old_q   <= old_q;
			out_drop_q  <= drop_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_drop_q, out_old_q, out_found_q};

	assign sts.hash_done    = hash_done;
	assign sts.clr_last     = (clr_q == BW'(NUM_BUCKETS - 1));
	assign sts.func         = func_q;
	assign sts.idx_lt_fill  = (idx_q < fill_q);
	assign sts.idx1_lt_fill = ({1'b0, idx_q} + (FW+1)'(1)) < {1'b0, fill_q};
	assign sts.key_match    = (key_rd_q == key_q);
	assign sts.full         = (fill_q >= FW'(BUCKET_DEPTH));
	assign sts.out_free     = !m_tvalid_q || m_tready;

endmodule

### hdl/cht_ctrl.sv
// cht_ctrl: controller of the hash table: clearing sweep, hash wait, bucket
// scan, append, remove shift and result hand-off. Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  cht_pkg::cht_sts_t sts,
	output cht_pkg::cht_cmd_t cmd
);
	import cht_pkg::*;

	typedef enum logic [10:0] {
		ST_CLR  = 11'b000_0000_0001,
		ST_IDLE = 11'b000_0000_0010,
		ST_HASH = 11'b000_0000_0100,
		ST_FRD  = 11'b000_0000_1000,
		ST_FLD  = 11'b000_0001_0000,
		ST_SRD  = 11'b000_0010_0000,
		ST_SCMP = 11'b000_0100_0000,
		ST_APP  = 11'b000_1000_0000,
		ST_HRD  = 11'b001_0000_0000,
		ST_HWR  = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.fill_op = FOP_CLR;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cmd.fill_we = 1'b1;
				cmd.clr_inc = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in    = 1'b1;
					cmd.hash_start = 1'b1;
					state_nxt      = ST_HASH;
				end
			end
			ST_HASH: begin
				if (sts.hash_done) begin
					state_nxt = ST_FRD;
				end
			end
			ST_FRD: state_nxt = ST_FLD;
			ST_FLD: begin
				cmd.fill_ld = 1'b1;
				cmd.idx_clr = 1'b1;
				state_nxt   = (sts.func == FUNC_ADD) ? ST_APP : ST_SRD;
			end
			ST_SRD: begin
				if (sts.idx_lt_fill) begin
					state_nxt = ST_SCMP;
				end else if (sts.func == FUNC_UPDATE) begin
					state_nxt = ST_APP;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_SCMP: begin
				if (sts.key_match) begin
					cmd.hit_ld = 1'b1;
					if (sts.func == FUNC_UPDATE) begin
						cmd.val_we = 1'b1;
						state_nxt  = ST_DONE;
					end else if (sts.func == FUNC_REMOVE) begin
						state_nxt = ST_HRD;
					end else begin
						state_nxt = ST_DONE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_SRD;
				end
			end
			ST_APP: begin
				if (sts.full) begin
					cmd.drop_set = 1'b1;
				end else begin
					cmd.wr_at_fill = 1'b1;
					cmd.key_we     = 1'b1;
					cmd.val_we     = 1'b1;
					cmd.fill_we    = 1'b1;
					cmd.fill_op    = FOP_INC;
				end
				state_nxt = ST_DONE;
			end
			// close the gap: entry idx+1 moves down to idx
			ST_HRD: begin
				cmd.rd_next = 1'b1;
				if (sts.idx1_lt_fill) begin
					state_nxt = ST_HWR;
				end else begin
					cmd.fill_we = 1'b1;
					cmd.fill_op = FOP_DEC;
					state_nxt   = ST_DONE;
				end
			end
			ST_HWR: begin
				cmd.shift_wr = 1'b1;
				cmd.key_we   = 1'b1;
				cmd.val_we   = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_nxt    = ST_HRD;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

### hdl/chained_hash_table_engine_top.sv
// Usage notes:
// Key/value table of chained buckets. Items enter on s_tvalid/s_tready/s_tdata
// (func, key, value); one result item per input leaves on m_tvalid/m_tready/
// m_tdata (found, old_value, dropped). cfg_wen/cfg_wdata write the bucket count,
// the modulus of the hash (key / 16); write it only while the block is idle.
// One item is worked at a time. The hash runs in a radix-64 modulo unit; then
// the fill count is read, and an add appends while the other operations scan
// the bucket entry by entry through the key and value memories, each with one
// read and one write port; a remove then moves each later entry down by one.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver only holds the following result. After reset
// the fill counts are cleared by a sweep over all buckets, during which
// s_tready is low; the bucket count resets to 64. Keys and values are not
// cleared: only entries below a bucket's fill count are ever read.
// Depends on cht_pkg, cht_ctrl, cht_dp, cht_hash.
`timescale 1ns / 1ps
module chained_hash_table_engine_top #(
	parameter int NUM_BUCKETS  = 64,
	parameter int BUCKET_DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [cht_pkg::CFG_W-1:0]       cfg_wdata,   // bucket_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cht_pkg::IN_TDATA_W-1:0]  s_tdata,     // func[1:0], key[65:2], value[129:66]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cht_pkg::OUT_TDATA_W-1:0] m_tdata      // found[0], old_value[64:1], dropped[65]
);
	import cht_pkg::*;

	cht_cmd_t cmd;
	cht_sts_t sts;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cht_dp #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	a_found_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[65]))
		else $error("found and dropped both set");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == '0))
		else $error("old_value nonzero on a miss");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in work");

	a_out_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result overwrote a waiting item");
`endif

endmodule

### tb/tb_chained_hash_table_engine_top.sv
// Testbench for chained_hash_table_engine_top: drives random and directed table
// operations, predicts each result with a behavioral bucket table in a scoreboard.
// Depends on cht_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_chained_hash_table_engine_top;
	import cht_pkg::*;

	localparam int NB = 64;
	localparam int BD = 8;
	localparam int MAX_CYCLES = 1000000;

	class table_scoreboard;
		logic [63:0] keys [NB*BD];
		logic [63:0] vals [NB*BD];
		int unsigned fill [NB];
		int unsigned buckets;
		logic [65:0] pending [$];
		int errors;

		function new();
			foreach (fill[i]) fill[i] = 0;
			buckets = 64;
			errors = 0;
		endfunction

		function void set_buckets(logic [6:0] v);
			buckets = (v == 0) ? 1 : (v > NB ? NB : v);
		endfunction

		function int unsigned bucket_of(logic [63:0] k);
			return int'((k >> 4) % 64'(buckets));
		endfunction

		function bit try_append(int unsigned b, logic [63:0] k, logic [63:0] v);
			if (fill[b] >= BD) return 1'b1;
			keys[b*BD+fill[b]] = k;
			vals[b*BD+fill[b]] = v;
			fill[b]++;
			return 1'b0;
		endfunction

		// Note an accepted item and queue {dropped, old_value, found}.
		function void note_item(func_t f, logic [63:0] k, logic [63:0] v);
			int unsigned b, base;
			int pos;
			logic hit, drop;
			logic [63:0] prev;
			b = bucket_of(k);
			base = b * BD;
			hit = 0; drop = 0; prev = 0; pos = -1;
			if (f == FUNC_ADD) begin
				drop = try_append(b, k, v);
			end else begin
				for (int i = 0; i < int'(fill[b]); i++)
					if (pos < 0 && keys[base+i] == k) pos = i;
				if (pos >= 0) begin
					hit = 1;
					prev = vals[base+pos];
					if (f == FUNC_UPDATE) begin
						vals[base+pos] = v;
					end else if (f == FUNC_REMOVE) begin
						for (int i = pos; i + 1 < int'(fill[b]); i++) begin
							keys[base+i] = keys[base+i+1];
							vals[base+i] = vals[base+i+1];
						end
						fill[b]--;
					end
				end else if (f == FUNC_UPDATE) begin
					drop = try_append(b, k, v);
				end
			end
			pending.push_back({drop, prev, hit});
		endfunction

		function void check_result(logic [71:0] d);
			logic [65:0] e;
			if (pending.size() == 0) begin
				$error("result item with nothing expected: %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e[0]) begin
				$error("found: expected %0d actual %0d", e[0], d[0]);
				errors++;
			end
			if (d[64:1] !== e[64:1]) begin
				$error("old_value: expected %h actual %h", e[64:1], d[64:1]);
				errors++;
			end
			if (d[65] !== e[65]) begin
				$error("dropped: expected %0d actual %0d", e[65], d[65]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wen = 0;
	logic [6:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	table_scoreboard sb;
	int send_idle_pct, recv_idle_pct;
	int cycles, n_items;
	logic [63:0] live_keys [$];

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	chained_hash_table_engine_top #(.NUM_BUCKETS(NB), .BUCKET_DEPTH(BD)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// receiver: random stalls, checks at each accepted result item
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// tvalid stays high after an accept until the next item or an idle gap
	task automatic send_item(func_t f, logic [63:0] k, logic [63:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, v, k, f};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(f, k, v);
		n_items++;
	endtask

	task automatic write_buckets(logic [6:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_buckets(v);
	endtask

	// keys mostly from a small pool so lookups hit; some fully random
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		if (live_keys.size() > 0 && $urandom_range(99) < 70)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		k = {$urandom, $urandom};
		if ($urandom_range(3) != 0) k[3:0] = 4'h0;
		if ($urandom_range(1)) k[63:12] = '0;
		if (live_keys.size() < 48) live_keys.push_back(k);
		return k;
	endfunction

	task automatic random_phase(int n);
		func_t f;
		repeat (n) begin
			f = func_t'($urandom_range(3));
			send_item(f, pick_key(), {$urandom, $urandom});
		end
	endtask

	initial begin
		logic [6:0] cfgs [6];
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cycles = 0;
		n_items = 0;
		cfgs = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd37};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, miss cases, full-bucket drop, duplicate ordering
		send_item(FUNC_GET, 64'd0, 64'd0);
		send_item(FUNC_REMOVE, '1, '1);
		send_item(FUNC_ADD, '1, '1);
		send_item(FUNC_ADD, '1, 64'd5);
		send_item(FUNC_GET, '1, 64'd0);
		send_item(FUNC_UPDATE, '1, 64'h5555_AAAA_0F0F_F0F0);
		send_item(FUNC_REMOVE, '1, 64'd0);
		send_item(FUNC_GET, '1, 64'd0);
		send_item(FUNC_UPDATE, 64'h40, 64'hAAAA_5555_F0F0_0F0F);
		for (int i = 0; i < 10; i++)
			send_item(FUNC_ADD, 64'(i) << 10, 64'(i));
		send_item(FUNC_REMOVE, 64'h800, 64'd0);
		send_item(FUNC_GET, 64'h1000, 64'd0);
		send_item(FUNC_UPDATE, 64'h2400, 64'd9);

		for (int ph = 0; ph < 6; ph++) begin
			write_buckets(cfgs[ph]);
			if (ph < 2) begin
				send_idle_pct = 7; recv_idle_pct = 88;
			end else if (ph < 4) begin
				send_idle_pct = 88; recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			live_keys.delete();
			random_phase(300);
		end

		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d items over bucket counts 1, 64, 0, 127, 5, 37", n_items);
		$display("all four operations, misses, duplicates and full-bucket drops");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### filelist.f
hdl/cht_pkg.sv
hdl/cht_hash.sv
hdl/cht_dp.sv
hdl/cht_ctrl.sv
hdl/chained_hash_table_engine_top.sv
tb/tb_chained_hash_table_engine_top.sv
